[hw/rtl/capture_period_tachometer_assert.svh]
// Assertion macros shared by the capture-period tachometer RTL.
`ifndef CAPTURE_PERIOD_TACHOMETER_ASSERT_SVH
`define CAPTURE_PERIOD_TACHOMETER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cpt_pkg.sv]
// Shared constants, codes and types of the capture-period tachometer.
`default_nettype none
package cpt_pkg;

  localparam int CapW     = 16;
  localparam int SpeedW   = 26;
  localparam int CfgW     = 8;
  localparam int CfgIdxW  = 2;
  localparam int DivisorW = CapW + CfgW;

  localparam logic [SpeedW-1:0] TachNum = 26'd60000000;

  localparam logic [CfgW-1:0] PprReset  = 8'd50;
  localparam logic [CfgW-1:0] ThrReset  = 8'd5;
  localparam logic [CfgW-1:0] SkipReset = 8'd5;

  localparam logic [CfgIdxW-1:0] REG_PPR       = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SKIP      = 2'd2;

  localparam logic OP_CAPTURE  = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EVAL = 4'b1000
  } cpt_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cpt_div_stat_t;

endpackage
`default_nettype wire

[hw/rtl/cpt_div.sv]
// Bit-serial restoring divider of the fixed tachometer numerator.
`default_nettype none
module cpt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cpt_pkg::DivisorW-1:0]  divisor,
  output logic [cpt_pkg::SpeedW-1:0]    quotient,
  output cpt_pkg::cpt_div_stat_t        stat
);
  import cpt_pkg::*;

  localparam int CntW = $clog2(SpeedW);
  localparam logic [CntW-1:0] LastStep = CntW'(SpeedW - 1);

  logic [DivisorW-1:0] dsr_r;
  logic [DivisorW-1:0] rem_r;
  logic [SpeedW-1:0]   qn_r;
  logic [CntW-1:0]     cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   trial_sub;
  logic                ge;

  assign trial     = {rem_r, qn_r[SpeedW-1]};
  assign trial_sub = trial - {1'b0, dsr_r};
  assign ge        = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastStep) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift in as the numerator bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= divisor;
      rem_r <= '0;
      qn_r  <= TachNum;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[DivisorW-1:0] : trial[DivisorW-1:0];
      qn_r  <= {qn_r[SpeedW-2:0], ge};
    end
  end

  assign quotient  = qn_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

[hw/rtl/capture_period_tachometer.sv]
// Top level of the capture-period tachometer: event sequencer and report logic.
//
//  Channel | Ports                                                         | Direction
//  --------+---------------------------------------------------------------+----------
//  in      | in_valid, in_ready, in_op, in_capture_value                   | sink
//  out     | out_valid, out_ready, out_speed_rpm, out_period_ticks         | source
//  cfg     | cfg_we, cfg_index, cfg_wdata                                  | sink
//
// Overflow words and skipped captures are taken in the idle state and keep in_ready high.
// A kept capture holds in_ready low through the multiply, divide and evaluate states; the divide
// state runs the 26 steps of the bit-serial divider, and a zero divisor bypasses it.
// Reset is synchronous and restores the register defaults and the zero state.
// A report waits in the output register; a new report stalls until it is taken.
`default_nettype none
`include "capture_period_tachometer_assert.svh"
module capture_period_tachometer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [cpt_pkg::CapW-1:0]     in_capture_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cpt_pkg::SpeedW-1:0]   out_speed_rpm,
  output logic [cpt_pkg::CapW-1:0]     out_period_ticks,
  input  logic                         cfg_we,
  input  logic [cpt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cpt_pkg::CfgW-1:0]     cfg_wdata
);
  import cpt_pkg::*;

  cpt_state_t          state_r;
  logic [CfgW-1:0]     ppr_r;
  logic [CfgW-1:0]     thr_r;
  logic [CfgW-1:0]     skip_cfg_r;
  logic                skip_pending_r;
  logic [CapW-1:0]     last_cap_r;
  logic [SpeedW-1:0]   last_speed_r;
  logic [CfgW-1:0]     count_r;
  logic [CapW-1:0]     period_r;
  logic [SpeedW-1:0]   speed_r;
  logic                out_valid_r;
  logic [SpeedW-1:0]   out_speed_r;
  logic [CapW-1:0]     out_period_r;

  logic                in_acc;
  logic [DivisorW-1:0] product;
  logic                div_start;
  logic [SpeedW-1:0]   div_quot;
  cpt_div_stat_t       div_stat;
  logic [SpeedW-1:0]   speed_diff;
  logic                changed;
  logic                report;
  logic                emit;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign product   = DivisorW'(period_r) * DivisorW'(ppr_r);
  assign div_start = (state_r == ST_MUL) && (product != '0);

  assign speed_diff = (speed_r >= last_speed_r) ? (speed_r - last_speed_r)
                                                : (last_speed_r - speed_r);
  assign changed = (speed_diff >= SpeedW'(thr_r));
  assign report  = changed && (count_r == skip_cfg_r);
  assign emit    = (state_r == ST_EVAL) && report && (!out_valid_r || out_ready);

  cpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (product),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r      <= PprReset;
      thr_r      <= ThrReset;
      skip_cfg_r <= SkipReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PPR:       ppr_r      <= cfg_wdata;
        REG_THRESHOLD: thr_r      <= cfg_wdata;
        REG_SKIP:      skip_cfg_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      skip_pending_r <= 1'b0;
      last_cap_r     <= '0;
      last_speed_r   <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_op == OP_OVERFLOW) begin
              skip_pending_r <= 1'b1;
            end else if (skip_pending_r) begin
              skip_pending_r <= 1'b0;
            end else begin
              last_cap_r <= in_capture_value;
              state_r    <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state_r <= (product == '0) ? ST_EVAL : ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!changed) begin
            state_r <= ST_IDLE;
          end else if (!report) begin
            count_r <= count_r + 1'b1;
            state_r <= ST_IDLE;
          end else if (emit) begin
            last_speed_r <= speed_r;
            count_r      <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      period_r <= in_capture_value - last_cap_r;
    end
    if (state_r == ST_MUL) begin
      speed_r <= TachNum;
    end else if (div_stat.done) begin
      speed_r <= div_quot;
    end
    if (emit) begin
      out_speed_r  <= speed_r;
      out_period_r <= period_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_speed_rpm    = out_speed_r;
  assign out_period_ticks = out_period_r;

  `CPT_ASSERT_NOW(a_div_in_div_state, div_stat.busy || div_stat.done,
                  state_r == ST_DIV, "divider active outside the divide state")
  `CPT_ASSERT_NOW(a_out_matches_last, out_valid_r, out_speed_r == last_speed_r,
                  "pending report differs from the last reported speed")
  `CPT_ASSERT_NEXT(a_emit_sets_valid, emit, out_valid_r && (state_r == ST_IDLE),
                   "report did not reach the output register")

endmodule
`default_nettype wire
